FILE: rtl/lcdnw_pkg.sv
// Shared types and constants for the character LCD nibble writer.
// Holds the request structs, the item kind codes and the fixed constants.
// No dependencies.
package lcdnw_pkg;

  // Item kinds
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_COMMAND = 2'd1;
  localparam logic [1:0] KIND_DECIMAL = 2'd2;
  localparam logic [1:0] KIND_BINARY  = 2'd3;

  // Decimal conversion sizes
  localparam int unsigned DEC_BITS   = 17;
  localparam int unsigned BCD_DIGITS = 5;
  localparam int unsigned BCD_BITS   = 4 * BCD_DIGITS;

  localparam logic [31:0] DECIMAL_MAX  = 32'd99999;
  localparam logic [7:0]  ASCII_ZERO   = 8'h30;
  localparam logic [7:0]  ASCII_ONE    = 8'h31;
  localparam logic [15:0] ENABLE_RESET = 16'd50000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic [5:0]  bit_count;
  } in_t;

  typedef struct packed {
    logic       register_select;
    logic [3:0] nibble;
    logic       last;
  } out_t;

endpackage

FILE: rtl/lcdnw_bcd.sv
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// Depends on lcdnw_pkg for the converter sizes.
module lcdnw_bcd (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [lcdnw_pkg::DEC_BITS-1:0] bin_i,
  output logic                           done_o,
  output logic [lcdnw_pkg::BCD_BITS-1:0] bcd_o
);
  import lcdnw_pkg::*;

  localparam int unsigned CntW = $clog2(DEC_BITS + 1);

  logic [DEC_BITS-1:0] bin_q;
  logic [BCD_BITS-1:0] bcd_q;
  logic [BCD_BITS-1:0] adj;
  logic [CntW-1:0]     cnt_q;
  logic                busy_q;
  logic                done_q;

  // Add three to every digit of five or more before the shift
  always_comb begin
    for (int d = 0; d < BCD_DIGITS; d++) begin
      adj[4*d +: 4] = (bcd_q[4*d +: 4] >= 4'd5) ? bcd_q[4*d +: 4] + 4'd3
                                                 : bcd_q[4*d +: 4];
    end
  end

  // Control: count the input bits through
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DEC_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift one binary bit into the BCD register per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bin_q <= bin_i;
      bcd_q <= '0;
    end else if (busy_q) begin
      bin_q <= {bin_q[DEC_BITS-2:0], 1'b0};
      bcd_q <= {adj[BCD_BITS-2:0], bin_q[DEC_BITS-1]};
    end
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

FILE: rtl/lcdnw_strobe.sv
// Enable strobe stage: holds one nibble request for the programmed pulse
// width, then offers it on the output channel. Depends on lcdnw_pkg.
module lcdnw_strobe (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [15:0]       pulse_cycles_i,
  input  logic              req_valid_i,
  input  lcdnw_pkg::out_t   req_i,
  output logic              req_ready_o,
  output logic              out_valid_o,
  output lcdnw_pkg::out_t   out_o,
  input  logic              out_stall_i
);
  import lcdnw_pkg::*;

  localparam logic [1:0] S_FREE  = 2'd0;
  localparam logic [1:0] S_PULSE = 2'd1;
  localparam logic [1:0] S_SHOW  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [15:0] cnt_q, cnt_d;
  out_t        out_q;

  assign req_ready_o = (state_q == S_FREE);
  assign out_valid_o = (state_q == S_SHOW);
  assign out_o       = out_q;

  // Next state: take a request, time the pulse, wait for the sink
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_FREE: begin
        if (req_valid_i) begin
          state_d = S_PULSE;
          cnt_d   = pulse_cycles_i;
        end
      end
      S_PULSE: begin
        if (cnt_q <= 16'd1) begin
          state_d = S_SHOW;
        end else begin
          cnt_d = cnt_q - 16'd1;
        end
      end
      S_SHOW: begin
        if (!out_stall_i) begin
          state_d = S_FREE;
        end
      end
      default: begin
        state_d = S_FREE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_FREE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Capture the request payload
  always_ff @(posedge clk_i) begin
    if (req_ready_o && req_valid_i) begin
      out_q <= req_i;
    end
  end

endmodule

FILE: rtl/lcdnw_seq.sv
// Item sequencer: turns one request into a series of nibble requests,
// shifting binary bits and BCD digits out serially. Depends on lcdnw_pkg
// and lcdnw_bcd.
module lcdnw_seq #(
  parameter int unsigned MAX_BINARY_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  lcdnw_pkg::in_t  in_i,
  output logic            in_stall_o,
  output logic            nib_valid_o,
  output lcdnw_pkg::out_t nib_o,
  input  logic            nib_ready_i
);
  import lcdnw_pkg::*;

  localparam int unsigned CW = $clog2(MAX_BINARY_BITS + 1);
  localparam logic [2:0]  LAST_PLACE = 3'(BCD_DIGITS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALIGN = 3'd1;
  localparam logic [2:0] S_BIN   = 3'd2;
  localparam logic [2:0] S_CONV  = 3'd3;
  localparam logic [2:0] S_DEC   = 3'd4;
  localparam logic [2:0] S_HI    = 3'd5;
  localparam logic [2:0] S_LO    = 3'd6;

  logic [2:0]                 state_q;
  logic [7:0]                 char_q;
  logic                       rs_q;
  logic                       final_q;
  logic                       is_bin_q;
  logic [MAX_BINARY_BITS-1:0] sreg_q;
  logic [CW-1:0]              cnt_q;
  logic [CW-1:0]              align_q;
  logic [BCD_BITS-1:0]        digits_q;
  logic [2:0]                 place_q;
  logic                       started_q;

  logic                       accept;
  logic [CW-1:0]              cnt_sat;
  logic [DEC_BITS-1:0]        dec_sat;
  logic                       bcd_done;
  logic [BCD_BITS-1:0]        bcd;
  logic [3:0]                 digit;
  logic                       emit_digit;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  // Clamp the bit count and the decimal value
  assign cnt_sat = (in_i.bit_count > 6'(MAX_BINARY_BITS)) ? CW'(MAX_BINARY_BITS)
                                                          : in_i.bit_count[CW-1:0];
  assign dec_sat = (in_i.value > DECIMAL_MAX) ? DECIMAL_MAX[DEC_BITS-1:0]
                                              : in_i.value[DEC_BITS-1:0];

  lcdnw_bcd u_bcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept && (in_i.kind == KIND_DECIMAL)),
    .bin_i  (dec_sat),
    .done_o (bcd_done),
    .bcd_o  (bcd)
  );

  // Leading digit and zero suppression
  assign digit      = digits_q[BCD_BITS-1 -: 4];
  assign emit_digit = (digit != 4'd0) || started_q || (place_q == LAST_PLACE);

  // Nibble request toward the strobe stage
  assign nib_valid_o = (state_q == S_HI) || (state_q == S_LO);
  always_comb begin
    nib_o.register_select = rs_q;
    nib_o.nibble          = (state_q == S_HI) ? char_q[7:4] : char_q[3:0];
    nib_o.last            = (state_q == S_LO) && final_q;
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      is_bin_q  <= 1'b0;
      final_q   <= 1'b0;
      cnt_q     <= '0;
      align_q   <= '0;
      place_q   <= '0;
      started_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            unique case (in_i.kind)
              KIND_DATA, KIND_COMMAND: begin
                is_bin_q <= 1'b0;
                final_q  <= 1'b1;
                state_q  <= S_HI;
              end
              KIND_DECIMAL: begin
                is_bin_q <= 1'b0;
                state_q  <= S_CONV;
              end
              KIND_BINARY: begin
                is_bin_q <= 1'b1;
                cnt_q    <= cnt_sat;
                align_q  <= CW'(MAX_BINARY_BITS) - cnt_sat;
                // A zero count produces no nibbles: drop the request
                if (cnt_sat != '0) begin
                  state_q <= S_ALIGN;
                end
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_ALIGN: begin
          if (align_q == '0) begin
            state_q <= S_BIN;
          end else begin
            align_q <= align_q - CW'(1);
          end
        end
        S_BIN: begin
          final_q <= (cnt_q == CW'(1));
          cnt_q   <= cnt_q - CW'(1);
          state_q <= S_HI;
        end
        S_CONV: begin
          if (bcd_done) begin
            place_q   <= '0;
            started_q <= 1'b0;
            state_q   <= S_DEC;
          end
        end
        S_DEC: begin
          place_q <= place_q + 3'd1;
          if (emit_digit) begin
            started_q <= 1'b1;
            final_q   <= (place_q == LAST_PLACE);
            state_q   <= S_HI;
          end
        end
        S_HI: begin
          if (nib_ready_i) begin
            state_q <= S_LO;
          end
        end
        S_LO: begin
          if (nib_ready_i) begin
            priority if (final_q) begin
              state_q <= S_IDLE;
            end else if (is_bin_q) begin
              state_q <= S_BIN;
            end else begin
              state_q <= S_DEC;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath: character byte, bit shifter, digit shifter
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        char_q <= in_i.value[7:0];
        rs_q   <= (in_i.kind != KIND_COMMAND);
        sreg_q <= in_i.value[MAX_BINARY_BITS-1:0];
      end
      S_ALIGN: begin
        if (align_q != '0) begin
          sreg_q <= sreg_q << 1;
        end
      end
      S_BIN: begin
        char_q <= sreg_q[MAX_BINARY_BITS-1] ? ASCII_ONE : ASCII_ZERO;
        rs_q   <= 1'b1;
        sreg_q <= sreg_q << 1;
      end
      S_CONV: begin
        digits_q <= bcd;
      end
      S_DEC: begin
        char_q   <= ASCII_ZERO | {4'd0, digit};
        rs_q     <= 1'b1;
        digits_q <= {digits_q[BCD_BITS-5:0], 4'd0};
      end
      default: begin
        char_q <= char_q;
      end
    endcase
  end

endmodule

FILE: rtl/char_lcd_nibble_writer_core.sv
// Top level of the character LCD nibble writer: pulse width register,
// item sequencer and enable strobe stage. Depends on lcdnw_pkg, lcdnw_seq,
// lcdnw_strobe.
//
//   channel   direction  payload            handshake
//   in        sink       lcdnw_pkg::in_t    in_valid_i / in_stall_o
//   out       source     lcdnw_pkg::out_t   out_valid_o / out_stall_i
//   cfg       sink       16-bit pulse width cfg_we_i / cfg_wdata_i
//
// One item at a time. The strobe timer holds every nibble for the
// programmed enable pulse width (a width of zero acts as one), then
// shows it until the sink stops stalling. A byte takes two nibbles; a
// decimal item first runs the serial BCD conversion, then picks digits,
// skipping leading zeros but always showing the last digit; a binary
// item first aligns its bits, then gives two nibbles a bit.
// Reset clears all control state and sets the pulse width to 50000.
module char_lcd_nibble_writer_core #(
  parameter int unsigned MAX_BINARY_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  lcdnw_pkg::in_t  in_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output lcdnw_pkg::out_t out_o,
  input  logic            cfg_we_i,
  input  logic [15:0]     cfg_wdata_i
);
  import lcdnw_pkg::*;

  logic [15:0] pulse_cycles_q;
  logic        nib_valid;
  logic        nib_ready;
  out_t        nib;

  // Enable pulse width register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_cycles_q <= ENABLE_RESET;
    end else if (cfg_we_i) begin
      pulse_cycles_q <= cfg_wdata_i;
    end
  end

  lcdnw_seq #(
    .MAX_BINARY_BITS(MAX_BINARY_BITS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_i       (in_i),
    .in_stall_o (in_stall_o),
    .nib_valid_o(nib_valid),
    .nib_o      (nib),
    .nib_ready_i(nib_ready)
  );

  lcdnw_strobe u_strobe (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pulse_cycles_i(pulse_cycles_q),
    .req_valid_i   (nib_valid),
    .req_i         (nib),
    .req_ready_o   (nib_ready),
    .out_valid_o   (out_valid_o),
    .out_o         (out_o),
    .out_stall_i   (out_stall_i)
  );

endmodule

FILE: rtl/lcdnw_checker.sv
// Port-level checks for the character LCD nibble writer, bound to the top.
// Depends on lcdnw_pkg and char_lcd_nibble_writer_core.
module lcdnw_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input lcdnw_pkg::in_t  in_i,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input lcdnw_pkg::out_t out_o
);
  import lcdnw_pkg::*;

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_o))
    else $error("stalled result changed");

  // A request is still in work while a non-final nibble is shown
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.last |-> in_stall_o)
    else $error("new request taken before the last nibble");

  // Byte and decimal requests always produce nibbles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_i.kind != KIND_BINARY) |=> in_stall_o)
    else $error("request finished without output");

endmodule

bind char_lcd_nibble_writer_core lcdnw_checker u_checker (.*);
